### rtl/core/pnpc_pkg.sv
package pnpc_pkg;

	localparam int NFIELDS  = 6;
	localparam int DEPTH_IX = 2;
	localparam int COORD_W  = 32;
	localparam int COUNT_W  = 8;

	// configuration register indexes
	localparam logic REG_NEAR_DEPTH  = 1'b0;
	localparam logic REG_COORD_COUNT = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef coord_t vec_t [NFIELDS];

	// sequencer to bisection unit
	typedef struct packed {
		logic start;
		logic drop;
	} bis_ctl_t;

	// bisection unit to sequencer
	typedef struct packed {
		logic running;
		logic done;
	} bis_stat_t;

endpackage

### rtl/core/polygon_near_plane_clipper_top.sv
// A result that needs no clipping goes from the step state into the output register once that is free;
// a clipped point is first halved toward the plane in the bisection state, one bisection step at a time.
// Only one vertex is in hand at a time; a clipped edge holds the input until the single halving unit,
// which serves all coordinates once per step, lands on the plane.
// A waiting result sits in the output register while the next vertex is taken.
// Reset (arst_n low, asynchronous): polygon state cleared, near_depth 1, coord_count 3.
module polygon_near_plane_clipper_top
	import pnpc_pkg::*;
#(
	parameter int MAX_COORDS        = 6,
	parameter int MAX_POLY_VERTICES = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] coord0,
	input  logic signed [COORD_W-1:0] coord1,
	input  logic signed [COORD_W-1:0] coord2,
	input  logic signed [COORD_W-1:0] coord3,
	input  logic signed [COORD_W-1:0] coord4,
	input  logic signed [COORD_W-1:0] coord5,
	input  logic                      end_of_polygon,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] out_coord0,
	output logic signed [COORD_W-1:0] out_coord1,
	output logic signed [COORD_W-1:0] out_coord2,
	output logic signed [COORD_W-1:0] out_coord3,
	output logic signed [COORD_W-1:0] out_coord4,
	output logic signed [COORD_W-1:0] out_coord5,
	output logic                      closing_copy,
	output logic                      last_of_polygon,
	output logic [COUNT_W-1:0]        vertex_total,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [COORD_W-1:0]        cfg_wdata
);

	// coordinate bound and count ceiling, settled at elaboration
	localparam int COORD_LIMIT = (MAX_COORDS < NFIELDS) ? MAX_COORDS : NFIELDS;
	localparam int CAP_RAW     = 2 * MAX_POLY_VERTICES;
	localparam int COUNT_CAP   = (CAP_RAW > 255) ? 255 : CAP_RAW;
	localparam logic [2:0]         USED_MAX  = 3'(COORD_LIMIT);
	localparam logic [2:0]         USED_MIN  = 3'd3;
	localparam logic [COUNT_W-1:0] CAP_Q     = COUNT_W'(COUNT_CAP);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_STEP = 2'd1;
	localparam logic [1:0] ST_BIS  = 2'd2;

	logic [1:0] state_q;

	// configuration
	coord_t     near_q;
	logic [2:0] cc_q;
	logic [2:0] used;

	// polygon state
	vec_t               cur_q, prev_q, first_q;
	logic               have_prev_q, have_first_q;
	logic [COUNT_W-1:0] count_q;

	// work still owed for the vertex in hand
	logic need_clip_q, need_cur_q, need_close_q, eop_q;
	logic clip_lo_prev_q;

	// output register
	vec_t               out_coord_q;
	logic               out_valid_q, closing_q, last_q;
	logic [COUNT_W-1:0] total_q;

	// bisection unit
	bis_ctl_t  bis_ctl;
	bis_stat_t bis_stat;
	vec_t      bis_lo, bis_hi, bis_m;

	vec_t in_vec, emit_src, emit_vec, close_vec;
	logic out_free;
	logic take_in, load_clip, load_cur, load_emit, load_close, finish;
	logic prev_beyond, cur_beyond;

	// clamp the coordinate count into the supported range
	always_comb begin
		if (cc_q < USED_MIN) begin
			used = USED_MIN;
		end else if (cc_q > USED_MAX) begin
			used = USED_MAX;
		end else begin
			used = cc_q;
		end
	end

	always_comb begin
		in_vec[0] = coord0;
		in_vec[1] = coord1;
		in_vec[2] = coord2;
		in_vec[3] = coord3;
		in_vec[4] = coord4;
		in_vec[5] = coord5;
	end

	// edge classification: which ends lie beyond the near plane
	assign cur_beyond  = coord2 > near_q;
	assign prev_beyond = prev_q[DEPTH_IX] > near_q;

	// the output register frees up when empty or when its request leaves this cycle
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		take_in    = 1'b0;
		load_clip  = 1'b0;
		load_cur   = 1'b0;
		load_close = 1'b0;
		finish     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				take_in = in_valid;
			end
			ST_STEP: begin
				// owed work in order: clipped point, later vertex, closing copy
				if (!need_clip_q) begin
					if (need_cur_q) begin
						load_cur = out_free;
					end else if (need_close_q) begin
						load_close = out_free;
					end else begin
						finish = 1'b1;
					end
				end
			end
			ST_BIS: begin
				load_clip = bis_stat.done && out_free;
			end
			default: begin
			end
		endcase
		load_emit = load_clip || load_cur;
	end

	assign in_ready = state_q == ST_IDLE;

	// the behind end is the low end of the bisection
	always_comb begin
		for (int j = 0; j < NFIELDS; j++) begin
			bis_lo[j] = clip_lo_prev_q ? prev_q[j] : cur_q[j];
			bis_hi[j] = clip_lo_prev_q ? cur_q[j] : prev_q[j];
		end
	end

	assign bis_ctl.start = (state_q == ST_STEP) && need_clip_q;
	assign bis_ctl.drop  = load_clip;

	pnpc_bisect u_bisect (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (bis_ctl),
		.lo         (bis_lo),
		.hi         (bis_hi),
		.near_depth (near_q),
		.stat       (bis_stat),
		.mid        (bis_m)
	);

	// zero the coordinates beyond the count in use
	always_comb begin
		for (int j = 0; j < NFIELDS; j++) begin
			emit_src[j]  = (state_q == ST_BIS) ? bis_m[j] : cur_q[j];
			emit_vec[j]  = (3'(j) < used) ? emit_src[j] : '0;
			close_vec[j] = have_first_q ? first_q[j] : '0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			near_q       <= coord_t'(1);
			cc_q         <= 3'd3;
			have_prev_q  <= 1'b0;
			have_first_q <= 1'b0;
			count_q      <= '0;
			need_clip_q  <= 1'b0;
			need_cur_q   <= 1'b0;
			need_close_q <= 1'b0;
			eop_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_NEAR_DEPTH:  near_q <= cfg_wdata;
					REG_COORD_COUNT: cc_q   <= cfg_wdata[2:0];
					default: begin
					end
				endcase
			end

			if (load_emit || load_close) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (take_in) begin
				need_clip_q  <= have_prev_q && (prev_beyond != cur_beyond);
				need_cur_q   <= have_prev_q && cur_beyond;
				need_close_q <= end_of_polygon;
				eop_q        <= end_of_polygon;
				state_q      <= ST_STEP;
			end

			if (bis_ctl.start) begin
				state_q <= ST_BIS;
			end

			if (load_clip) begin
				need_clip_q <= 1'b0;
				state_q     <= ST_STEP;
			end

			if (load_cur) begin
				need_cur_q <= 1'b0;
			end

			// count each emitted vertex, holding at the ceiling
			if (load_emit) begin
				have_first_q <= 1'b1;
				if (count_q < CAP_Q) begin
					count_q <= count_q + COUNT_W'(1);
				end
			end

			// the closing copy ends the polygon
			if (load_close) begin
				need_close_q <= 1'b0;
				have_first_q <= 1'b0;
				count_q      <= '0;
			end

			if (finish) begin
				have_prev_q <= !eop_q;
				state_q     <= ST_IDLE;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (take_in) begin
			cur_q          <= in_vec;
			clip_lo_prev_q <= cur_beyond;
		end
		if (finish) begin
			prev_q <= cur_q;
		end
		if (load_emit && !have_first_q) begin
			first_q <= emit_vec;
		end
		if (load_emit) begin
			out_coord_q <= emit_vec;
			closing_q   <= 1'b0;
			last_q      <= 1'b0;
			total_q     <= '0;
		end else if (load_close) begin
			out_coord_q <= close_vec;
			closing_q   <= 1'b1;
			last_q      <= 1'b1;
			total_q     <= count_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_coord0      = out_coord_q[0];
	assign out_coord1      = out_coord_q[1];
	assign out_coord2      = out_coord_q[2];
	assign out_coord3      = out_coord_q[3];
	assign out_coord4      = out_coord_q[4];
	assign out_coord5      = out_coord_q[5];
	assign closing_copy    = closing_q;
	assign last_of_polygon = last_q;
	assign vertex_total    = total_q;

	// one vertex in hand at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a vertex is still in hand");

	// the running count never passes its ceiling
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_Q)
		else $error("vertex count above its ceiling");

	// the final request of a polygon is a closing copy, and only it carries a total
	a_last_is_closing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_polygon |-> closing_copy)
		else $error("final request is not a closing copy");

	a_total_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_polygon |-> vertex_total == '0)
		else $error("vertex total on a request that is not the last");

	// the halving unit runs only while the sequencer waits on it
	a_bis_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		bis_stat.running |-> state_q == ST_BIS)
		else $error("bisection running outside its state");

endmodule

### rtl/core/pnpc_bisect.sv
module pnpc_bisect
	import pnpc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  bis_ctl_t  ctl,
	input  vec_t      lo,
	input  vec_t      hi,
	input  coord_t    near_depth,
	output bis_stat_t stat,
	output vec_t      mid
);

	vec_t l_q, r_q, m_q;
	vec_t nl, nr, nm;
	logic run_q;
	logic hit, below;
	logic signed [COORD_W:0] sum [NFIELDS];

	// one halving step over every lane: pick the side, then average
	always_comb begin
		hit   = m_q[DEPTH_IX] == near_depth;
		below = m_q[DEPTH_IX] < near_depth;
		for (int j = 0; j < NFIELDS; j++) begin
			nl[j]  = below ? m_q[j] : l_q[j];
			nr[j]  = below ? r_q[j] : m_q[j];
			sum[j] = {nl[j][COORD_W-1], nl[j]} + {nr[j][COORD_W-1], nr[j]};
			nm[j]  = sum[j][COORD_W:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (ctl.start) begin
			run_q <= 1'b1;
		end else if (ctl.drop) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			l_q <= lo;
			m_q <= lo;
			r_q <= hi;
		end else if (run_q && !hit) begin
			l_q <= nl;
			r_q <= nr;
			m_q <= nm;
		end
	end

	assign stat.running = run_q;
	assign stat.done    = run_q && hit;
	assign mid          = m_q;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

// Near-plane clipper bench.
// Vertex requests are queued by the sequence block below and offered by a clocked
// driver; every request that the clipper takes is run through a local clipping
// predictor, which queues the vertices the clipper should emit. A clocked monitor
// takes the emitted vertices and compares them, field by field, with the oldest
// queued prediction.
module tb_top;
	import pnpc_pkg::*;

	localparam int MAX_COORDS        = 6;
	localparam int MAX_POLY_VERTICES = 64;
	localparam int COORD_LIMIT       = (MAX_COORDS < NFIELDS) ? MAX_COORDS : NFIELDS;
	localparam int COUNT_CAP         = (2 * MAX_POLY_VERTICES > 255) ? 255 : 2 * MAX_POLY_VERTICES;
	localparam int SETTLE_CYCLES     = 100;     // worst bisection plus emission, with margin
	localparam int LONG_HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT       = 1000000;

	localparam logic [COORD_W-1:0] S32_MAX = 32'h7fffffff;
	localparam logic [COORD_W-1:0] S32_MIN = 32'h80000000;

	typedef logic [NFIELDS-1:0][COORD_W-1:0] vtx_t;

	typedef struct packed {
		vtx_t c;
		logic eop;
	} vertex_req_t;

	typedef struct packed {
		vtx_t               c;
		logic               closing;
		logic               is_last;
		logic [COUNT_W-1:0] total;
	} clip_vertex_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [COORD_W-1:0] coord0 = '0;
	logic signed [COORD_W-1:0] coord1 = '0;
	logic signed [COORD_W-1:0] coord2 = '0;
	logic signed [COORD_W-1:0] coord3 = '0;
	logic signed [COORD_W-1:0] coord4 = '0;
	logic signed [COORD_W-1:0] coord5 = '0;
	logic                      end_of_polygon = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [COORD_W-1:0] out_coord0;
	logic signed [COORD_W-1:0] out_coord1;
	logic signed [COORD_W-1:0] out_coord2;
	logic signed [COORD_W-1:0] out_coord3;
	logic signed [COORD_W-1:0] out_coord4;
	logic signed [COORD_W-1:0] out_coord5;
	logic                      closing_copy;
	logic                      last_of_polygon;
	logic [COUNT_W-1:0]        vertex_total;
	logic                      cfg_we = 1'b0;
	logic                      cfg_index = REG_NEAR_DEPTH;
	logic [COORD_W-1:0]        cfg_wdata = '0;

	polygon_near_plane_clipper_top #(
		.MAX_COORDS       (MAX_COORDS),
		.MAX_POLY_VERTICES(MAX_POLY_VERTICES)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.coord0         (coord0),
		.coord1         (coord1),
		.coord2         (coord2),
		.coord3         (coord3),
		.coord4         (coord4),
		.coord5         (coord5),
		.end_of_polygon (end_of_polygon),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_coord0     (out_coord0),
		.out_coord1     (out_coord1),
		.out_coord2     (out_coord2),
		.out_coord3     (out_coord3),
		.out_coord4     (out_coord4),
		.out_coord5     (out_coord5),
		.closing_copy   (closing_copy),
		.last_of_polygon(last_of_polygon),
		.vertex_total   (vertex_total),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata)
	);

	// Requests waiting to be offered, and vertices the clipper still owes us.
	vertex_req_t  vertex_req_q[$];
	clip_vertex_t clipped_q[$];

	// Predictor copy of the clipper's registers and polygon state.
	logic signed [COORD_W-1:0] near_depth_r   = 32'sd1;
	logic [2:0]                coord_count_r  = 3'd3;
	vtx_t                      prev_v         = '0;
	vtx_t                      first_v        = '0;
	bit                        have_prev      = 1'b0;
	bit                        have_first     = 1'b0;
	int unsigned               emit_cnt       = 0;

	int send_idle_pct   = 0;
	int recv_stall_pct  = 0;
	int long_hold_left  = 0;
	int reqs_queued     = 0;
	int reqs_taken      = 0;
	int results_seen    = 0;
	int clip_points     = 0;
	int polygons_closed = 0;
	int saturated_polys = 0;
	int mismatches      = 0;
	int cycle_cnt       = 0;

	vertex_req_t  drv_req;
	clip_vertex_t mon_got;
	clip_vertex_t mon_want;
	bit           mon_bad;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Clipping predictor
	// ---------------------------------------------------------------------

	function automatic int used_coords();
		int n;
		n = coord_count_r;
		if (n < 3) n = 3;
		if (n > COORD_LIMIT) n = COORD_LIMIT;
		return n;
	endfunction

	// Halve every used coordinate between the behind end and the front end
	// until depth lands on the plane; sums are taken at full width.
	function automatic vtx_t bisect_to_plane(vtx_t lo, vtx_t hi, int used);
		vtx_t   l;
		vtx_t   r;
		vtx_t   m;
		bit     go_left;
		longint s;
		m = lo;
		l = lo;
		r = hi;
		go_left = 1'b1;
		while ($signed(m[DEPTH_IX]) != near_depth_r) begin
			if (go_left) l = m;
			else r = m;
			for (int j = 0; j < used; j++) begin
				s = longint'($signed(l[j])) + longint'($signed(r[j]));
				m[j] = s[32:1];
			end
			go_left = $signed(m[DEPTH_IX]) < near_depth_r;
		end
		return m;
	endfunction

	task automatic emit_point(input vtx_t v, input int used);
		vtx_t m;
		m = '0;
		for (int j = 0; j < used; j++) m[j] = v[j];
		clipped_q.push_back('{c: m, closing: 1'b0, is_last: 1'b0, total: '0});
		if (!have_first) begin
			first_v = m;
			have_first = 1'b1;
		end
		if (emit_cnt < COUNT_CAP) emit_cnt++;
	endtask

	task automatic clip_step(input vtx_t cur, input logic eop);
		vtx_t lo;
		vtx_t hi;
		bit   earlier_low;
		int   used;
		used = used_coords();
		if (have_prev) begin
			earlier_low = $signed(prev_v[DEPTH_IX]) < $signed(cur[DEPTH_IX]);
			lo = earlier_low ? prev_v : cur;
			hi = earlier_low ? cur : prev_v;
			if ($signed(hi[DEPTH_IX]) > near_depth_r) begin
				if ($signed(lo[DEPTH_IX]) <= near_depth_r) begin
					emit_point(bisect_to_plane(lo, hi, used), used);
					clip_points++;
					if (earlier_low) emit_point(cur, used);
				end else begin
					emit_point(cur, used);
				end
			end
		end
		prev_v = cur;
		have_prev = 1'b1;
		if (eop) begin
			// closing copy of the first emitted vertex, or an empty terminator
			clipped_q.push_back('{c: have_first ? first_v : '0, closing: 1'b1, is_last: 1'b1,
				total: have_first ? COUNT_W'(emit_cnt) : '0});
			if (emit_cnt == COUNT_CAP) saturated_polys++;
			polygons_closed++;
			have_prev = 1'b0;
			have_first = 1'b0;
			emit_cnt = 0;
			first_v = '0;
		end
	endtask

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	function automatic vtx_t mk_vtx(logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic [31:0] a, logic [31:0] b, logic [31:0] d);
		vtx_t v;
		v[0] = x; v[1] = y; v[2] = z; v[3] = a; v[4] = b; v[5] = d;
		return v;
	endfunction

	// Near depth plus an offset, clamped to the 32-bit signed range.
	function automatic logic [31:0] near_offset(longint off);
		longint t;
		t = longint'(near_depth_r) + off;
		if (t > 64'sd2147483647) t = 64'sd2147483647;
		if (t < -64'sd2147483648) t = -64'sd2147483648;
		return t[31:0];
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(9))
			0: return S32_MAX;
			1: return S32_MIN;
			2, 3, 4: return $urandom_range(0, 200) - 32'd100;
			default: return $urandom;
		endcase
	endfunction

	// Depths cluster around the plane, on both sides of it; a front vertex lies just in front.
	function automatic logic [31:0] rand_depth(bit front);
		if (front) return near_offset(longint'($urandom_range(1, 1000)));
		case ($urandom_range(7))
			0: return near_offset(longint'($urandom_range(0, 6)) - 3);
			1, 2, 3: return near_offset(longint'($urandom_range(0, 2000)) - 1000);
			4: return near_offset(longint'($urandom_range(1, 50)));
			5: return $urandom;
			6: return S32_MIN;
			default: return S32_MAX;
		endcase
	endfunction

	function automatic vtx_t rand_vertex(bit front);
		vtx_t v;
		for (int j = 0; j < NFIELDS; j++) v[j] = rand_coord();
		v[DEPTH_IX] = rand_depth(front);
		return v;
	endfunction

	task automatic push_vertex(input vtx_t v, input logic eop);
		vertex_req_q.push_back('{c: v, eop: eop});
		reqs_queued++;
	endtask

	// Closed polygon of nv vertices; a proper one closes on a repeat of its
	// first vertex, a broken one on some other vertex. nv of 0 gives a lone
	// closing vertex.
	task automatic push_polygon(input int nv, input bit proper, input bit front);
		vtx_t v;
		vtx_t first;
		first = rand_vertex(front);
		for (int k = 0; k < nv; k++) begin
			v = (k == 0) ? first : rand_vertex(front);
			push_vertex(v, 1'b0);
		end
		push_vertex((proper && nv > 0) ? first : rand_vertex(front), 1'b1);
	endtask

	task automatic random_phase(input int n_items);
		int goal;
		int pick;
		goal = reqs_queued + n_items;
		while (reqs_queued < goal) begin
			pick = $urandom_range(99);
			if (pick < 78) push_polygon($urandom_range(1, 7), 1'b1, 1'b0);
			else if (pick < 88) push_polygon($urandom_range(1, 5), 1'b0, 1'b0);
			else if (pick < 93) push_polygon(0, 1'b1, 1'b0);
			else push_vertex(rand_vertex(1'b0), 1'b0);   // stray vertex, runs into the next polygon
		end
	endtask

	// Write the near depth, then the coordinate count; the predictor follows at once,
	// since nothing is in flight when this is called.
	task automatic set_config(input logic [31:0] near, input logic [2:0] ccount);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_NEAR_DEPTH;
		cfg_wdata <= near;
		@(posedge clk);
		cfg_index <= REG_COORD_COUNT;
		cfg_wdata <= {29'd0, ccount};
		@(posedge clk);
		cfg_we <= 1'b0;
		near_depth_r  = near;
		coord_count_r = ccount;
		@(negedge clk);
	endtask

	// Hold until every request is taken and every vertex has come back, then
	// let the work still in hand in the clipper run out.
	task automatic wait_idle();
		do @(negedge clk);
		while (vertex_req_q.size() != 0 || in_valid || clipped_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic string fmt_vertex(clip_vertex_t r);
		return $sformatf("c=%0d/%0d/%0d/%0d/%0d/%0d closing=%0b last=%0b total=%0d",
			$signed(r.c[0]), $signed(r.c[1]), $signed(r.c[2]), $signed(r.c[3]),
			$signed(r.c[4]), $signed(r.c[5]), r.closing, r.is_last, r.total);
	endfunction

	// ---------------------------------------------------------------------
	// Request driver: offer the next queued vertex whenever the slot is free,
	// idling at random; hold payload steady while the clipper stalls us.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				clip_step(drv_req.c, drv_req.eop);
				reqs_taken++;
			end
			if (!in_valid || in_ready) begin
				if (vertex_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_req = vertex_req_q.pop_front();
					coord0         <= drv_req.c[0];
					coord1         <= drv_req.c[1];
					coord2         <= drv_req.c[2];
					coord3         <= drv_req.c[3];
					coord4         <= drv_req.c[4];
					coord5         <= drv_req.c[5];
					end_of_polygon <= drv_req.eop;
					in_valid       <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result monitor: take each emitted vertex and compare it with the oldest
	// prediction; stall at random, and throughout a long hold.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				mon_got.c[0]    = out_coord0;
				mon_got.c[1]    = out_coord1;
				mon_got.c[2]    = out_coord2;
				mon_got.c[3]    = out_coord3;
				mon_got.c[4]    = out_coord4;
				mon_got.c[5]    = out_coord5;
				mon_got.closing = closing_copy;
				mon_got.is_last = last_of_polygon;
				mon_got.total   = vertex_total;
				if (clipped_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected vertex at %0t: %s", $realtime, fmt_vertex(mon_got));
				end else begin
					mon_want = clipped_q.pop_front();
					mon_bad = (mon_got.closing !== mon_want.closing)
						|| (mon_got.is_last !== mon_want.is_last)
						|| (mon_got.total !== mon_want.total);
					for (int j = 0; j < NFIELDS; j++)
						if (mon_got.c[j] !== mon_want.c[j]) mon_bad = 1'b1;
					if (mon_bad) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch at %0t, vertex %0d", $realtime, results_seen);
							$display("  expected %s", fmt_vertex(mon_want));
							$display("  actual   %s", fmt_vertex(mon_got));
						end
					end
				end
			end
			out_ready <= (long_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Long output hold: count down in its own process once armed.
	always @(posedge clk) begin
		if (long_hold_left > 0) long_hold_left <= long_hold_left - 1;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d vertices outstanding", cycle_cnt,
				clipped_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: near plane at 1, three coordinates.
		// Lone closing vertex: no edge, empty terminator.
		push_vertex(mk_vtx(7, -7, 3, 1, 2, 3), 1'b1);
		// All in front; the extra attributes must come back as zero.
		push_vertex(mk_vtx(1, 2, 5, 11, 12, 13), 1'b0);
		push_vertex(mk_vtx(3, 4, 9, 14, 15, 16), 1'b0);
		push_vertex(mk_vtx(5, 6, 7, 17, 18, 19), 1'b0);
		push_vertex(mk_vtx(1, 2, 5, 11, 12, 13), 1'b1);
		// All behind, one vertex sitting on the plane: empty polygon.
		push_vertex(mk_vtx(0, 0, 1, 0, 0, 0), 1'b0);
		push_vertex(mk_vtx(9, 9, -7, 0, 0, 0), 1'b0);
		push_vertex(mk_vtx(0, 0, 1, 0, 0, 0), 1'b1);
		// Behind end already on the plane, then a clip in the other direction.
		push_vertex(mk_vtx(0, 0, 1, 0, 0, 0), 1'b0);
		push_vertex(mk_vtx(10, 20, 9, 0, 0, 0), 1'b0);
		push_vertex(mk_vtx(4, 4, -3, 0, 0, 0), 1'b0);
		push_vertex(mk_vtx(0, 0, 1, 0, 0, 0), 1'b1);
		wait_idle();

		// Plane at the bottom of the range, coordinate count above the bound.
		set_config(S32_MIN, 3'd7);
		push_vertex(mk_vtx(S32_MAX, S32_MIN, S32_MIN, S32_MAX, S32_MIN, S32_MAX), 1'b0);
		push_vertex(mk_vtx(S32_MIN, S32_MAX, S32_MAX, S32_MIN, S32_MAX, S32_MIN), 1'b0);
		push_vertex(mk_vtx(S32_MAX, S32_MIN, S32_MIN, S32_MAX, S32_MIN, S32_MAX), 1'b1);
		wait_idle();

		// Plane at the top: nothing can be in front. Count below three.
		set_config(S32_MAX, 3'd0);
		push_vertex(mk_vtx(S32_MAX, S32_MIN, S32_MAX, 1, 1, 1), 1'b0);
		push_vertex(mk_vtx(0, -1, S32_MIN, 2, 2, 2), 1'b0);
		push_vertex(mk_vtx(S32_MAX, S32_MIN, S32_MAX, 1, 1, 1), 1'b1);
		wait_idle();

		// Full-range edge through a plane at zero: the longest bisection.
		set_config(32'd0, 3'd6);
		push_vertex(mk_vtx(S32_MAX, S32_MIN, S32_MIN, S32_MAX, S32_MIN, S32_MAX), 1'b0);
		push_vertex(mk_vtx(S32_MIN, S32_MAX, S32_MAX, S32_MIN, S32_MAX, S32_MIN), 1'b0);
		push_vertex(mk_vtx(S32_MAX, S32_MIN, S32_MIN, S32_MAX, S32_MIN, S32_MAX), 1'b1);
		wait_idle();

		// Random phases. No idling first, with one polygon long enough to
		// drive the vertex count into saturation.
		set_config($urandom_range(0, 40) - 32'd20, 3'd4);
		push_polygon(COUNT_CAP + 8, 1'b1, 1'b1);
		random_phase(75);
		wait_idle();

		// Sender idle about half the time.
		set_config($urandom, 3'd5);
		send_idle_pct  = 51;
		recv_stall_pct = 0;
		random_phase(75);
		wait_idle();

		// Receiver stalling about half the time.
		set_config($urandom_range(0, 40) - 32'd20, 3'($urandom_range(0, 7)));
		send_idle_pct  = 0;
		recv_stall_pct = 51;
		random_phase(75);
		wait_idle();

		// Both sides idling; pause the sender midway until all vertices are back.
		set_config($urandom_range(0, 40) - 32'd20, 3'd6);
		send_idle_pct  = 28;
		recv_stall_pct = 28;
		random_phase(40);
		wait_idle();
		random_phase(40);
		wait_idle();

		// Long output hold with the sender pushing flat out, so the clipper
		// backs up and stalls its input.
		set_config($urandom_range(0, 40) - 32'd20, 3'd3);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		long_hold_left = LONG_HOLD_CYCLES;
		random_phase(35);
		wait_idle();

		$display("run: %0d vertex requests, %0d emitted vertices checked, %0d clipped points",
			reqs_taken, results_seen, clip_points);
		$display("run: %0d polygons closed, %0d at the count bound, %0d mismatches",
			polygons_closed, saturated_polys, mismatches);
		if (mismatches == 0 && clipped_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### polygon_near_plane_clipper_top.f
rtl/core/pnpc_pkg.sv
rtl/core/pnpc_bisect.sv
rtl/core/polygon_near_plane_clipper_top.sv
tb/tb_top.sv
